// ----- rtl/sss_pkg.sv -----
package sss_pkg;

  typedef struct packed {
    logic [7:0] in_char;
    logic       is_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic [1:0] kind;
    logic       last;
  } out_item_t;

  typedef enum logic [3:0] {
    MODE_NORMAL = 4'd0,
    MODE_DASH1  = 4'd1,
    MODE_DASH2  = 4'd2,
    MODE_BRACE  = 4'd3,
    MODE_LINE   = 4'd4,
    MODE_BLOCK  = 4'd5,
    MODE_SQUOTE = 4'd6,
    MODE_DQUOTE = 4'd7,
    MODE_ESC    = 4'd8
  } scan_mode_t;

  localparam logic [1:0] KIND_TEXT  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam int unsigned MAX_RES = 3;

endpackage

// ----- rtl/sql_statement_splitter.sv -----
// SQL statement splitter and comment stripper.
// The input channel (in_valid, in_stall, in_data) takes one byte of SQL text
// per item, or an end-of-input marker when in_data.is_end is set.
// The result channel (out_valid, out_stall, out_data) gives text bytes with
// comments blanked to spaces, statement ends and open-quote or open-comment
// errors. Each input item causes zero to three result items, and the final
// one carries out_data.last.
// An accepted item is held in an input register, decoded against the scanner
// state and its results are loaded into a three-entry result register, from
// which the result channel gives them out in order.
// Items that cause at most one result sustain one item per cycle unless the
// receiver stalls. An item with two or three results holds the result
// register until all have gone, as the result channel moves one item per cycle.
// When the receiver stalls, the result register holds its contents, the
// input register fills and in_stall rises until room is made again.
// Reset returns the scanner to normal text and empties both registers.
module sql_statement_splitter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sss_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sss_pkg::out_item_t  out_data
);
  import sss_pkg::*;

  logic       in_vld_r;
  in_item_t   in_r;
  scan_mode_t mode_r, mode_nxt;
  logic       qesc_r, qesc_nxt;
  out_item_t  res_r   [MAX_RES];
  out_item_t  res_nxt [MAX_RES];
  logic [1:0] rem_r;
  logic [1:0] n_res;

  logic       in_acc, pop, buf_free, proc_fire;

  logic       nb_emit, nb_qclr;
  out_item_t  nb_res;
  scan_mode_t nb_mode;
  out_item_t  lb_res, bb_res;
  scan_mode_t lb_mode, bb_mode;
  logic [7:0] closer;
  out_item_t  txt_ch;

  assign out_valid = (rem_r != 2'd0);
  assign out_data  = res_r[0];
  assign pop       = out_valid && !out_stall;
  assign buf_free  = (rem_r == 2'd0) || ((rem_r == 2'd1) && pop);
  assign proc_fire = in_vld_r && buf_free;
  assign in_stall  = in_vld_r && !proc_fire;
  assign in_acc    = in_valid && !in_stall;

  always_comb begin
    txt_ch  = '{out_char: in_r.in_char, kind: KIND_TEXT, last: 1'b0};
    nb_emit = 1'b1;
    nb_qclr = 1'b0;
    nb_res  = txt_ch;
    nb_mode = MODE_NORMAL;
    case (in_r.in_char)
      CH_SEMI: begin
        nb_res = '{out_char: 8'h00, kind: KIND_END, last: 1'b0};
      end
      CH_DASH: begin
        nb_emit = 1'b0;
        nb_mode = MODE_DASH1;
      end
      CH_LBRACE: begin
        nb_emit = 1'b0;
        nb_mode = MODE_BRACE;
      end
      CH_BSLASH: begin
        nb_mode = MODE_ESC;
      end
      CH_SQUOTE: begin
        nb_mode = MODE_SQUOTE;
        nb_qclr = 1'b1;
      end
      CH_DQUOTE: begin
        nb_mode = MODE_DQUOTE;
        nb_qclr = 1'b1;
      end
      default: begin
        nb_mode = MODE_NORMAL;
      end
    endcase

    if (in_r.in_char == CH_NL) begin
      lb_res  = txt_ch;
      lb_mode = MODE_NORMAL;
    end else begin
      lb_res  = '{out_char: CH_SPACE, kind: KIND_TEXT, last: 1'b0};
      lb_mode = MODE_LINE;
    end

    bb_res  = '{out_char: CH_SPACE, kind: KIND_TEXT, last: 1'b0};
    bb_mode = (in_r.in_char == CH_RBRACE) ? MODE_NORMAL : MODE_BLOCK;
    closer  = (mode_r == MODE_SQUOTE) ? CH_SQUOTE : CH_DQUOTE;
  end

  always_comb begin
    n_res    = 2'd0;
    mode_nxt = mode_r;
    qesc_nxt = qesc_r;
    for (int i = 0; i < MAX_RES; i++) begin
      res_nxt[i] = '{out_char: 8'h00, kind: KIND_TEXT, last: 1'b0};
    end

    if (in_r.is_end) begin
      case (mode_r)
        MODE_SQUOTE, MODE_DQUOTE, MODE_LINE, MODE_BLOCK: begin
          res_nxt[0] = '{out_char: 8'h00, kind: KIND_ERROR, last: 1'b0};
          n_res      = 2'd1;
        end
        MODE_DASH1: begin
          res_nxt[0] = '{out_char: CH_DASH, kind: KIND_TEXT, last: 1'b0};
          res_nxt[1] = '{out_char: 8'h00, kind: KIND_END, last: 1'b0};
          n_res      = 2'd2;
        end
        MODE_DASH2: begin
          res_nxt[0] = '{out_char: CH_DASH, kind: KIND_TEXT, last: 1'b0};
          res_nxt[1] = '{out_char: CH_DASH, kind: KIND_TEXT, last: 1'b0};
          res_nxt[2] = '{out_char: 8'h00, kind: KIND_END, last: 1'b0};
          n_res      = 2'd3;
        end
        MODE_BRACE: begin
          res_nxt[0] = '{out_char: CH_LBRACE, kind: KIND_TEXT, last: 1'b0};
          res_nxt[1] = '{out_char: 8'h00, kind: KIND_END, last: 1'b0};
          n_res      = 2'd2;
        end
        default: begin
          res_nxt[0] = '{out_char: 8'h00, kind: KIND_END, last: 1'b0};
          n_res      = 2'd1;
        end
      endcase
      mode_nxt = MODE_NORMAL;
      qesc_nxt = 1'b0;
    end else begin
      case (mode_r)
        MODE_DASH1: begin
          if (in_r.in_char == CH_DASH) begin
            mode_nxt = MODE_DASH2;
          end else begin
            res_nxt[0] = '{out_char: CH_DASH, kind: KIND_TEXT, last: 1'b0};
            res_nxt[1] = nb_res;
            n_res      = {1'b0, nb_emit} + 2'd1;
            mode_nxt   = nb_mode;
            if (nb_qclr) begin
              qesc_nxt = 1'b0;
            end
          end
        end
        MODE_DASH2: begin
          if (in_r.in_char == CH_PLUS) begin
            res_nxt[0] = '{out_char: CH_DASH, kind: KIND_TEXT, last: 1'b0};
            res_nxt[1] = '{out_char: CH_DASH, kind: KIND_TEXT, last: 1'b0};
            res_nxt[2] = txt_ch;
            mode_nxt   = MODE_NORMAL;
          end else begin
            res_nxt[0] = '{out_char: CH_SPACE, kind: KIND_TEXT, last: 1'b0};
            res_nxt[1] = '{out_char: CH_SPACE, kind: KIND_TEXT, last: 1'b0};
            res_nxt[2] = lb_res;
            mode_nxt   = lb_mode;
          end
          n_res = 2'd3;
        end
        MODE_BRACE: begin
          if (in_r.in_char == CH_PLUS) begin
            res_nxt[0] = '{out_char: CH_LBRACE, kind: KIND_TEXT, last: 1'b0};
            res_nxt[1] = txt_ch;
            mode_nxt   = MODE_NORMAL;
          end else begin
            res_nxt[0] = '{out_char: CH_SPACE, kind: KIND_TEXT, last: 1'b0};
            res_nxt[1] = bb_res;
            mode_nxt   = bb_mode;
          end
          n_res = 2'd2;
        end
        MODE_LINE: begin
          res_nxt[0] = lb_res;
          n_res      = 2'd1;
          mode_nxt   = lb_mode;
        end
        MODE_BLOCK: begin
          res_nxt[0] = bb_res;
          n_res      = 2'd1;
          mode_nxt   = bb_mode;
        end
        MODE_SQUOTE, MODE_DQUOTE: begin
          res_nxt[0] = txt_ch;
          n_res      = 2'd1;
          if (qesc_r) begin
            qesc_nxt = 1'b0;
          end else if (in_r.in_char == CH_BSLASH) begin
            qesc_nxt = 1'b1;
          end else if (in_r.in_char == closer) begin
            mode_nxt = MODE_NORMAL;
          end
        end
        MODE_ESC: begin
          res_nxt[0] = txt_ch;
          n_res      = 2'd1;
          mode_nxt   = MODE_NORMAL;
        end
        default: begin
          res_nxt[0] = nb_res;
          n_res      = {1'b0, nb_emit};
          mode_nxt   = nb_mode;
          if (nb_qclr) begin
            qesc_nxt = 1'b0;
          end
        end
      endcase
    end

    res_nxt[0].last = (n_res == 2'd1);
    res_nxt[1].last = (n_res == 2'd2);
    res_nxt[2].last = (n_res == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      mode_r   <= MODE_NORMAL;
      qesc_r   <= 1'b0;
      rem_r    <= 2'd0;
    end else begin
      in_vld_r <= (in_vld_r && !proc_fire) || in_acc;
      if (proc_fire) begin
        mode_r <= mode_nxt;
        qesc_r <= qesc_nxt;
        rem_r  <= n_res;
      end else if (pop) begin
        rem_r <= rem_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r <= in_data;
    end
    if (proc_fire) begin
      for (int i = 0; i < MAX_RES; i++) begin
        res_r[i] <= res_nxt[i];
      end
    end else if (pop) begin
      res_r[0] <= res_r[1];
      res_r[1] <= res_r[2];
    end
  end

  // The scanner always leaves an end-of-input item in normal text.
  assert property (@(posedge clk) disable iff (!rst_n)
    proc_fire && in_r.is_end |=> (mode_r == MODE_NORMAL) && !qesc_r)
    else $error("scanner not in normal text after end of input");

  // Only the final pending result carries the last flag.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last == (rem_r == 2'd1)))
    else $error("last flag does not match pending result count");

  // An error is always the only result of its item.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_ERROR) |-> out_data.last)
    else $error("error result followed by further results");

  // Stalling the input only happens with an item waiting in the input register.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r && out_valid)
    else $error("input stalled without a held item and pending results");

endmodule
